[sv/bwga_pkg.sv]
package bwga_pkg;

  localparam int COORD_W  = 32;
  localparam int SUM_W    = 52;
  localparam int DIV_NW   = 52;
  localparam int DIV_DW   = 32;
  localparam int DIV_CW   = 6;
  localparam int CELLS_W  = 11;
  localparam int SPAN_W   = 37;
  localparam int HITS_W   = 20;
  localparam int CFG_IW   = 3;
  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  localparam logic [CFG_IW-1:0] CFG_X_START = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_X_STEP  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_X_CELLS = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_X_WIDTH = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_Y_START = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_Y_STEP  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_Y_CELLS = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_Y_WIDTH = 3'd7;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    DOP_XLO = 3'd0,
    DOP_XHI = 3'd1,
    DOP_YLO = 3'd2,
    DOP_YHI = 3'd3,
    DOP_AVG = 3'd4
  } dop_t;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic div_start;
    dop_t div_op;
    logic span_ld;
    logic cell_init;
    logic cell_rd;
    logic cell_wr;
    logic rd_cell;
    logic avg_ld;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic div_done;
    logic span_empty;
    logic cell_last;
    logic clr_last;
    logic rd_zero;
    logic out_free;
  } sts_t;

  // Cells in use, forced into the range one to the grid maximum.
  function automatic logic [CELLS_W-1:0] eff_cells(input logic [6:0] c,
                                                   input logic [CELLS_W-1:0] mx);
    logic [CELLS_W-1:0] cw;
    cw = CELLS_W'(c);
    if (c == 7'd0) return CELLS_W'(1);
    if (cw > mx) return mx;
    return cw;
  endfunction

endpackage

[sv/bwga_in_if.sv]
interface bwga_in_if
  import bwga_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [31:0]        intensity;
  logic [5:0]                cell_col;
  logic [5:0]                cell_row;

  modport source(output valid, req_type, point_x, point_y, intensity, cell_col, cell_row,
                 input ready);
  modport sink(input valid, req_type, point_x, point_y, intensity, cell_col, cell_row,
               output ready);
endinterface

[sv/bwga_out_if.sv]
interface bwga_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average;
  logic [19:0]        hits;
  logic               is_empty;

  modport source(output valid, average, hits, is_empty, input ready);
  modport sink(input valid, average, hits, is_empty, output ready);
endinterface

[sv/bwga_div.sv]
module bwga_div
  import bwga_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo,
  output logic [DIV_DW-1:0] rem
);

  logic [DIV_NW-1:0] n_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW+1:0] diff;

  // One quotient bit a cycle, restoring form.
  assign sh   = {rem_r, n_r[DIV_NW-1]};
  assign diff = {1'b0, sh} - {2'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r <= {n_r[DIV_NW-2:0], ~diff[DIV_DW+1]};
      if (!diff[DIV_DW+1]) begin
        rem_r <= diff[DIV_DW-1:0];
      end else begin
        rem_r <= sh[DIV_DW-1:0];
      end
    end
  end

  assign done = done_r;
  assign quo  = n_r;
  assign rem  = rem_r;

endmodule

[sv/bwga_dp.sv]
module bwga_dp
  import bwga_pkg::*;
#(
  parameter int MAX_X_CELLS = 64,
  parameter int MAX_Y_CELLS = 64,
  parameter int COUNT_BITS  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      cfg_we,
  input  logic [CFG_IW-1:0]         cfg_idx,
  input  logic [31:0]               cfg_wdata,
  input  logic [1:0]                in_req_type,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [31:0]        in_intensity,
  input  logic [5:0]                in_cell_col,
  input  logic [5:0]                in_cell_row,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_average,
  output logic [HITS_W-1:0]         out_hits,
  output logic                      out_is_empty
);

  localparam int DEPTH = MAX_X_CELLS * MAX_Y_CELLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XIW   = (MAX_X_CELLS > 1) ? $clog2(MAX_X_CELLS) : 1;
  localparam int YIW   = (MAX_Y_CELLS > 1) ? $clog2(MAX_Y_CELLS) : 1;
  localparam int MW    = COUNT_BITS + SUM_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Configuration registers.
  logic signed [31:0] x_start_r, y_start_r;
  logic [30:0]        x_step_r, y_step_r, x_width_r, y_width_r;
  logic [6:0]         x_cells_r, y_cells_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r <= '0;  x_step_r <= 31'd65536; x_cells_r <= 7'd64; x_width_r <= 31'd65536;
      y_start_r <= '0;  y_step_r <= 31'd65536; y_cells_r <= 7'd64; y_width_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_X_START: x_start_r <= cfg_wdata;
        CFG_X_STEP:  x_step_r  <= cfg_wdata[30:0];
        CFG_X_CELLS: x_cells_r <= cfg_wdata[6:0];
        CFG_X_WIDTH: x_width_r <= cfg_wdata[30:0];
        CFG_Y_START: y_start_r <= cfg_wdata;
        CFG_Y_STEP:  y_step_r  <= cfg_wdata[30:0];
        CFG_Y_CELLS: y_cells_r <= cfg_wdata[6:0];
        CFG_Y_WIDTH: y_width_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Latched request payload.
  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [31:0]        val_r;
  logic [5:0]                col_r, row_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      val_r <= in_intensity;
      col_r <= in_cell_col;
      row_r <= in_cell_row;
    end
  end

  logic [CELLS_W-1:0] nx, ny;
  assign nx = eff_cells(x_cells_r, CELLS_W'(MAX_X_CELLS));
  assign ny = eff_cells(y_cells_r, CELLS_W'(MAX_Y_CELLS));

  // Span numerator 2(q - start) -/+ width, and denominator 2 step.
  logic                is_x, is_lo;
  logic signed [32:0]  rel;
  logic signed [34:0]  num_s;
  logic [34:0]         num_mag;
  logic [30:0]         stp, wid;
  logic [DIV_DW-1:0]   span_den;

  assign is_x  = (cmd.div_op == DOP_XLO) || (cmd.div_op == DOP_XHI);
  assign is_lo = (cmd.div_op == DOP_XLO) || (cmd.div_op == DOP_YLO);
  assign stp   = is_x ? x_step_r : y_step_r;
  assign wid   = is_x ? x_width_r : y_width_r;
  assign rel   = is_x ? ({px_r[31], px_r} - {x_start_r[31], x_start_r})
                      : ({py_r[31], py_r} - {y_start_r[31], y_start_r});
  assign num_s = is_lo ? ({rel[32], rel, 1'b0} - $signed({4'b0, wid}))
                       : ({rel[32], rel, 1'b0} + $signed({4'b0, wid}));
  assign num_mag  = num_s[34] ? 35'(-num_s) : 35'(num_s);
  assign span_den = {((stp == '0) ? 31'd1 : stp), 1'b0};

  // Memory word and read port.
  logic [MW-1:0]         rdata_r;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic signed [SUM_W-1:0] rd_sum;
  assign rd_cnt = rdata_r[MW-1:SUM_W];
  assign rd_sum = rdata_r[SUM_W-1:0];

  logic [SUM_W-1:0] sum_mag;
  assign sum_mag = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);

  // Shared divider.
  logic [DIV_NW-1:0] dv_num, dv_quo;
  logic [DIV_DW-1:0] dv_den, dv_rem;
  logic              dv_done;

  assign dv_num = (cmd.div_op == DOP_AVG) ? DIV_NW'(sum_mag) : DIV_NW'(num_mag);
  assign dv_den = (cmd.div_op == DOP_AVG) ? DIV_DW'(rd_cnt) : span_den;

  bwga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo),
    .rem   (dv_rem)
  );

  // Ceiling for the low bound, floor for the high bound.
  logic signed [SPAN_W-1:0] qs, span_val;
  logic                     rnz;
  assign qs  = $signed({2'b0, dv_quo[34:0]});
  assign rnz = |dv_rem;
  always_comb begin
    if (num_s[34]) begin
      span_val = is_lo ? -qs : (-qs - SPAN_W'(rnz));
    end else begin
      span_val = is_lo ? (qs + SPAN_W'(rnz)) : qs;
    end
  end

  logic signed [SPAN_W-1:0] xa_r, xb_r, ya_r, yb_r;
  always_ff @(posedge clk) begin
    if (cmd.span_ld) begin
      case (cmd.div_op)
        DOP_XLO: xa_r <= span_val;
        DOP_XHI: xb_r <= span_val;
        DOP_YLO: ya_r <= span_val;
        DOP_YHI: yb_r <= span_val;
        default: ;
      endcase
    end
  end

  logic signed [SPAN_W-1:0] nxm1, nym1;
  logic                     x_empty, y_empty;
  logic [XIW-1:0]           xlo, xhi;
  logic [YIW-1:0]           ylo, yhi;
  assign nxm1    = $signed(SPAN_W'(nx)) - SPAN_W'(1);
  assign nym1    = $signed(SPAN_W'(ny)) - SPAN_W'(1);
  assign x_empty = (xa_r > xb_r) || (xa_r > nxm1) || (xb_r < 0);
  assign y_empty = (ya_r > yb_r) || (ya_r > nym1) || (yb_r < 0);
  assign xlo     = (xa_r < 0) ? '0 : xa_r[XIW-1:0];
  assign ylo     = (ya_r < 0) ? '0 : ya_r[YIW-1:0];
  assign xhi     = (xb_r > nxm1) ? nxm1[XIW-1:0] : xb_r[XIW-1:0];
  assign yhi     = (yb_r > nym1) ? nym1[YIW-1:0] : yb_r[YIW-1:0];

  // Cell walk, column outer and row inner.
  logic [XIW-1:0] cc_r, xhi_r;
  logic [YIW-1:0] cr_r, ylo_r, yhi_r;
  logic           cell_last;
  assign cell_last = (cc_r == xhi_r) && (cr_r == yhi_r);

  always_ff @(posedge clk) begin
    if (cmd.cell_init) begin
      cc_r  <= xlo;
      cr_r  <= ylo;
      xhi_r <= xhi;
      ylo_r <= ylo;
      yhi_r <= yhi;
    end else if (cmd.cell_wr && !cell_last) begin
      if (cr_r == yhi_r) begin
        cc_r <= cc_r + 1'b1;
        cr_r <= ylo_r;
      end else begin
        cr_r <= cr_r + 1'b1;
      end
    end
  end

  // Clearing sweep address.
  logic [AW-1:0] clr_addr_r;
  logic          clr_last;
  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  // Accumulate one point into the cell just read.
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_new;
  logic                    cnt_full;
  assign sum_ext  = {rd_sum[SUM_W-1], rd_sum} + (SUM_W+1)'(val_r);
  assign cnt_full = (rd_cnt == CNT_MAX);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_new = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SUM_W-1:0];
    end
  end

  logic [AW-1:0] cell_addr, rd_addr, mem_raddr, mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_we, mem_re;
  assign cell_addr = AW'(AW'(cc_r) * AW'(MAX_Y_CELLS) + AW'(cr_r));
  assign rd_addr   = AW'(AW'(col_r) * AW'(MAX_Y_CELLS) + AW'(row_r));
  assign mem_raddr = cmd.rd_cell ? rd_addr : cell_addr;
  assign mem_re    = cmd.rd_cell || cmd.cell_rd;
  assign mem_we    = cmd.clr_wr || (cmd.cell_wr && !cnt_full);
  assign mem_waddr = cmd.clr_wr ? clr_addr_r : cell_addr;
  assign mem_wdata = cmd.clr_wr ? '0 : {rd_cnt + 1'b1, sum_new};

  logic [MW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // Read result.
  logic                  in_grid;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [31:0]           cnt32;
  logic [31:0]           avg;
  assign in_grid = (CELLS_W'(col_r) < nx) && (CELLS_W'(row_r) < ny);
  assign cnt_eff = in_grid ? rd_cnt : '0;
  assign cnt32   = 32'(cnt_eff);

  always_comb begin
    if (cnt_eff == '0) begin
      avg = '0;
    end else if (!rd_sum[SUM_W-1]) begin
      avg = (dv_quo > DIV_NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dv_quo[31:0];
    end else begin
      avg = (dv_quo > DIV_NW'(32'h80000000)) ? 32'h80000000 : 32'(-dv_quo[31:0]);
    end
  end

  logic               out_valid_r, out_empty_r;
  logic signed [31:0] out_avg_r;
  logic [HITS_W-1:0]  out_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.avg_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_ld) begin
      out_avg_r   <= avg;
      out_hits_r  <= (cnt32 > 32'(HITS_MAX)) ? HITS_MAX : cnt32[HITS_W-1:0];
      out_empty_r <= (cnt_eff == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_average  = out_avg_r;
  assign out_hits     = out_hits_r;
  assign out_is_empty = out_empty_r;

  assign sts.req        = req_t'(in_req_type);
  assign sts.div_done   = dv_done;
  assign sts.span_empty = x_empty || y_empty;
  assign sts.cell_last  = cell_last;
  assign sts.clr_last   = clr_last;
  assign sts.rd_zero    = (cnt_eff == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

[sv/bwga_ctrl.sv]
module bwga_ctrl
  import bwga_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DSTART = 10'b0000000100,
    S_DWAIT  = 10'b0000001000,
    S_CINIT  = 10'b0000010000,
    S_CRD    = 10'b0000100000,
    S_CWR    = 10'b0001000000,
    S_RCELL  = 10'b0010000000,
    S_RAVG   = 10'b0100000000,
    S_PUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  dop_t   op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      op_r    <= DOP_XLO;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.div_op = (state_r == S_RAVG) ? DOP_AVG : op_r;
    state_nxt  = state_r;
    op_nxt     = op_r;
    in_ready   = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          case (sts.req)
            REQ_CLEAR: state_nxt = S_CLR;
            REQ_ADD: begin
              op_nxt    = DOP_XLO;
              state_nxt = S_DSTART;
            end
            REQ_READ: state_nxt = S_RCELL;
            default: ;
          endcase
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          if (op_r == DOP_AVG) begin
            state_nxt = S_PUT;
          end else begin
            cmd.span_ld = 1'b1;
            case (op_r)
              DOP_XLO: begin op_nxt = DOP_XHI; state_nxt = S_DSTART; end
              DOP_XHI: begin op_nxt = DOP_YLO; state_nxt = S_DSTART; end
              DOP_YLO: begin op_nxt = DOP_YHI; state_nxt = S_DSTART; end
              default: state_nxt = S_CINIT;
            endcase
          end
        end
      end
      S_CINIT: begin
        cmd.cell_init = 1'b1;
        state_nxt     = sts.span_empty ? S_IDLE : S_CRD;
      end
      S_CRD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_CWR;
      end
      S_CWR: begin
        cmd.cell_wr = 1'b1;
        state_nxt   = sts.cell_last ? S_IDLE : S_CRD;
      end
      S_RCELL: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = S_RAVG;
      end
      S_RAVG: begin
        if (sts.rd_zero) begin
          state_nxt = S_PUT;
        end else begin
          cmd.div_start = 1'b1;
          op_nxt        = DOP_AVG;
          state_nxt     = S_DWAIT;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.avg_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[sv/box_window_grid_averager_top.sv]
// Add request: four span divisions, a set-up step, a read and a write per covered cell.
// Read request: a cell read, then the average division unless empty or off-grid.
// Clear request: one write per grid cell, MAX_X_CELLS*MAX_Y_CELLS (4096 by default).
// One request is in work at a time; the shared bit-serial divider and the cell memory
// do its work. Reset is synchronous, active low, and is followed by a clearing pass
// over all MAX_X_CELLS*MAX_Y_CELLS cells during which no request is taken.
module box_window_grid_averager_top
  import bwga_pkg::*;
#(
  parameter int MAX_X_CELLS = 64,
  parameter int MAX_Y_CELLS = 64,
  parameter int COUNT_BITS  = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  bwga_in_if.sink           in_ch,
  bwga_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [31:0]       cfg_wdata
);

  // The controller only sequences; every register of the request lives in the datapath.
  cmd_t cmd;
  sts_t sts;
  logic ready;

  bwga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = ready;

  // The datapath holds the configuration, the divider, the cell memory and the
  // output register, so a finished read result can wait while the next request starts.
  bwga_dp #(
    .MAX_X_CELLS (MAX_X_CELLS),
    .MAX_Y_CELLS (MAX_Y_CELLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_req_type  (in_ch.req_type),
    .in_point_x   (in_ch.point_x),
    .in_point_y   (in_ch.point_y),
    .in_intensity (in_ch.intensity),
    .in_cell_col  (in_ch.cell_col),
    .in_cell_row  (in_ch.cell_row),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_average  (out_ch.average),
    .out_hits     (out_ch.hits),
    .out_is_empty (out_ch.is_empty)
  );

endmodule

[sv/bwga_chk.sv]
module bwga_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_average,
  input logic [19:0] out_hits,
  input logic        out_is_empty
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_hits))
    else $error("result changed while stalled");

  // An empty cell reports no hits and a zero average.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_hits == 20'd0 && out_average == 32'd0)
    else $error("empty cell with hits or average");

  a_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty |-> out_hits != 20'd0)
    else $error("covered cell with no hits");

  // in_ready is low at the start of the clearing pass that follows a reset cycle.
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind box_window_grid_averager_top bwga_chk u_bwga_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_average  (out_ch.average),
  .out_hits     (out_ch.hits),
  .out_is_empty (out_ch.is_empty)
);
